/* rtl/mnb_pkg.sv */
// Shared constants and types for the masked neighbour blur.
`timescale 1ns / 1ps

package mnb_pkg;

    localparam int PIXEL_BITS       = 16;
    localparam int WEIGHT_FRAC_BITS = 8;
    localparam int WEIGHT_BITS      = 9;
    localparam int NPOS             = 9;
    localparam int CENTRE_POS       = 4;
    localparam int COUNT_BITS       = 4;

    localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = WEIGHT_BITS'(128);

    // neighbour sum over eight positions, weighted product, numerator
    localparam int NBR_SUM_BITS = PIXEL_BITS + 3;
    localparam int PROD_BITS    = NBR_SUM_BITS + WEIGHT_BITS + 1;
    localparam int NUM_BITS     = ((PIXEL_BITS + WEIGHT_FRAC_BITS) > PROD_BITS) ?
                                  (PIXEL_BITS + WEIGHT_FRAC_BITS + 1) : (PROD_BITS + 1);
    // divisor: 2^F + 8 * max weight
    localparam int DEN_BITS     = (((WEIGHT_FRAC_BITS + 1) > (WEIGHT_BITS + 3)) ?
                                   (WEIGHT_FRAC_BITS + 1) : (WEIGHT_BITS + 3)) + 1;
    localparam int Q_BITS       = PIXEL_BITS;

    localparam int IN_TDATA_BITS  = ((NPOS * PIXEL_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = ((PIXEL_BITS + COUNT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic                           hit;
        logic signed [PIXEL_BITS-1:0]   val;
    } t_lane;

    typedef struct packed {
        logic signed [NBR_SUM_BITS-1:0] nsum;
        logic signed [PIXEL_BITS-1:0]   cent;
        logic [DEN_BITS-1:0]            den;
        logic                           smoothed;
        logic [COUNT_BITS-1:0]          count;
    } t_merge;

    typedef struct packed {
        logic [DEN_BITS-1:0]            rem;
        logic [Q_BITS-1:0]              quo;
        logic [DEN_BITS-1:0]            den;
        logic                           neg;
        logic                           smoothed;
        logic [COUNT_BITS-1:0]          count;
    } t_div;

endpackage

/* rtl/masked_neighbour_blur.sv */
// Masked, normalised 3x3 smoothing of one pixel per item.
// Usage:
//   Slave side takes one 3x3 window per item: nine signed 16-bit pixels in
//   tdata (nw at the lowest bits up to se) and one usable bit per position
//   in tuser (bit 0 nw .. bit 8 se). Master side returns one item per window:
//   tdata holds out_value and used_count, tuser holds the smoothed flag.
//   The neighbour weight (Q1.8) is written through i_cfg_wr_en/i_cfg_wr_data
//   while no item is in flight; reset loads 128.
//   Throughput: one item per cycle while the receiver is not stalled. An item
//   passes 21 register stages from the accepting edge to o_m_tvalid: the
//   16-stage quotient pipeline (one bit per stage) plus lane, merge,
//   numerator, magnitude and output registers.
//   Each stage holds its item when the next one is full and stalled, so a
//   stalled receiver fills the empty stages first; o_s_tready falls only
//   when every stage is occupied.
//   Reset empties the pipeline; items in flight are dropped.
`timescale 1ns / 1ps

module masked_neighbour_blur import mnb_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [WEIGHT_BITS-1:0]     i_cfg_wr_data,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    // pix_nw, pix_n, pix_ne, pix_w, pix_c, pix_e, pix_sw, pix_s, pix_se
    input  logic [IN_TDATA_BITS-1:0]   i_s_tdata,
    // usable_bits
    input  logic [NPOS-1:0]            i_s_tuser,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    // out_value, used_count, zero fill
    output logic [OUT_TDATA_BITS-1:0]  o_m_tdata,
    // smoothed
    output logic                       o_m_tuser
);

    localparam int DIV_FIRST = 4;
    localparam int NS        = DIV_FIRST + Q_BITS + 1;
    localparam logic [Q_BITS-1:0] POS_MAX = {1'b0, {(Q_BITS-1){1'b1}}};
    localparam logic [Q_BITS-1:0] NEG_MAX = {1'b1, {(Q_BITS-1){1'b0}}};

    logic [WEIGHT_BITS-1:0] r_weight;
    logic [NS-1:0]          r_vld;
    logic [NS-1:0]          stg_en;
    logic [NS-1:0]          vld_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= WEIGHT_RESET;
        end else if (i_cfg_wr_en) begin
            r_weight <= i_cfg_wr_data;
        end
    end

    // stage valid chain
    assign stg_en[NS-1] = !r_vld[NS-1] || i_m_tready;
    for (genvar k = 0; k < NS - 1; k++) begin : g_en
        assign stg_en[k] = !r_vld[k] || stg_en[k+1];
    end
    assign vld_in = {r_vld[NS-2:0], i_s_tvalid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (stg_en[k]) begin
                    r_vld[k] <= vld_in[k];
                end
            end
        end
    end

    assign o_s_tready = stg_en[0];

    // lanes
    t_lane                        lanes [NPOS];
    logic signed [PIXEL_BITS-1:0] r_centre;

    for (genvar p = 0; p < NPOS; p++) begin : g_lane
        mnb_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (stg_en[0]),
            .i_pix    ($signed(i_s_tdata[p*PIXEL_BITS +: PIXEL_BITS])),
            .i_usable (i_s_tuser[p]),
            .o_lane   (lanes[p])
        );
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r_centre <= $signed(i_s_tdata[CENTRE_POS*PIXEL_BITS +: PIXEL_BITS]);
        end
    end

    // merge
    t_merge merged;

    mnb_merge u_merge (
        .i_clk    (i_clk),
        .i_en     (stg_en[1]),
        .i_lanes  (lanes),
        .i_centre (r_centre),
        .i_weight (r_weight),
        .o_merge  (merged)
    );

    // numerator
    logic signed [PROD_BITS-1:0] nbr_prod;
    logic signed [NUM_BITS-1:0]  r_num;
    logic [DEN_BITS-1:0]         r_s2_den;
    logic                        r_s2_smoothed;
    logic [COUNT_BITS-1:0]       r_s2_count;

    assign nbr_prod = PROD_BITS'(merged.nsum)
                      * PROD_BITS'($signed({1'b0, r_weight}));

    always_ff @(posedge i_clk) begin
        if (stg_en[2]) begin
            r_num         <= (NUM_BITS'(merged.cent) <<< WEIGHT_FRAC_BITS)
                             + NUM_BITS'(nbr_prod);
            r_s2_den      <= merged.den;
            r_s2_smoothed <= merged.smoothed;
            r_s2_count    <= merged.count;
        end
    end

    // magnitude and divider load
    t_div div_pipe [Q_BITS+1];
    t_div r_div_ld;
    t_div n_div_ld;

    always_comb begin
        logic [NUM_BITS-1:0] mag;

        mag = r_num[NUM_BITS-1] ? NUM_BITS'(-r_num) : NUM_BITS'(r_num);
        n_div_ld.rem      = DEN_BITS'(mag >> Q_BITS);
        n_div_ld.quo      = mag[Q_BITS-1:0];
        n_div_ld.den      = r_s2_den;
        n_div_ld.neg      = r_num[NUM_BITS-1];
        n_div_ld.smoothed = r_s2_smoothed;
        n_div_ld.count    = r_s2_count;
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[3]) begin
            r_div_ld <= n_div_ld;
        end
    end

    assign div_pipe[0] = r_div_ld;

    for (genvar j = 0; j < Q_BITS; j++) begin : g_div
        mnb_div_step u_step (
            .i_clk (i_clk),
            .i_en  (stg_en[DIV_FIRST+j]),
            .i_div (div_pipe[j]),
            .o_div (div_pipe[j+1])
        );
    end

    // sign, clamp and output register
    t_div                       last;
    logic [PIXEL_BITS-1:0]      n_out_value;
    logic [PIXEL_BITS-1:0]      r_out_value;
    logic                       r_out_smoothed;
    logic [COUNT_BITS-1:0]      r_out_count;

    assign last = div_pipe[Q_BITS];

    always_comb begin
        if (!last.neg && (last.quo > POS_MAX)) begin
            n_out_value = PIXEL_BITS'(POS_MAX);
        end else if (last.neg && (last.quo > NEG_MAX)) begin
            n_out_value = PIXEL_BITS'(NEG_MAX);
        end else if (last.neg) begin
            n_out_value = PIXEL_BITS'(-last.quo);
        end else begin
            n_out_value = PIXEL_BITS'(last.quo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[NS-1]) begin
            r_out_value    <= n_out_value;
            r_out_smoothed <= last.smoothed;
            r_out_count    <= last.count;
        end
    end

    assign o_m_tvalid = r_vld[NS-1];
    assign o_m_tdata  = OUT_TDATA_BITS'({r_out_count, r_out_value});
    assign o_m_tuser  = r_out_smoothed;

endmodule

/* rtl/mnb_lane.sv */
// One window position: qualifies the pixel and registers its contribution.
`timescale 1ns / 1ps

module mnb_lane import mnb_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [PIXEL_BITS-1:0]  i_pix,
    input  logic                          i_usable,
    output t_lane                         o_lane
);

    t_lane r_lane;
    t_lane n_lane;

    always_comb begin
        n_lane.hit = i_usable && (i_pix != '0);
        n_lane.val = n_lane.hit ? i_pix : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

/* rtl/mnb_merge.sv */
// Merges the lanes: neighbour sum, count and divisor.
`timescale 1ns / 1ps

module mnb_merge import mnb_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  t_lane                         i_lanes [NPOS],
    input  logic signed [PIXEL_BITS-1:0]  i_centre,
    input  logic [WEIGHT_BITS-1:0]        i_weight,
    output t_merge                        o_merge
);

    t_merge r_merge;
    t_merge n_merge;

    always_comb begin
        logic signed [NBR_SUM_BITS-1:0] nsum;
        logic [COUNT_BITS-1:0]          cnt;
        logic [COUNT_BITS-1:0]          cm1;
        logic                           smth;

        nsum = '0;
        cnt  = '0;
        for (int i = 0; i < NPOS; i++) begin
            cnt = cnt + COUNT_BITS'(i_lanes[i].hit);
            if (i != CENTRE_POS) begin
                nsum = nsum + NBR_SUM_BITS'(i_lanes[i].val);
            end
        end
        smth  = i_lanes[CENTRE_POS].hit;
        cm1   = smth ? (cnt - COUNT_BITS'(1)) : '0;

        // a centre that does not count divides by 2^F: value passes through
        n_merge.nsum     = smth ? nsum : '0;
        n_merge.cent     = i_centre;
        n_merge.den      = DEN_BITS'(1 << WEIGHT_FRAC_BITS)
                           + DEN_BITS'(cm1) * DEN_BITS'(i_weight);
        n_merge.smoothed = smth;
        n_merge.count    = smth ? cnt : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_merge <= n_merge;
        end
    end

    assign o_merge = r_merge;

endmodule

/* rtl/mnb_div_step.sv */
// One restoring division step: one quotient bit per stage.
`timescale 1ns / 1ps

module mnb_div_step import mnb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_div  i_div,
    output t_div  o_div
);

    t_div r_div;
    t_div n_div;

    always_comb begin
        logic [DEN_BITS:0] trial;
        logic              ge;

        trial = {i_div.rem, i_div.quo[Q_BITS-1]};
        ge    = trial >= {1'b0, i_div.den};
        n_div = i_div;
        n_div.rem = ge ? DEN_BITS'(trial - {1'b0, i_div.den}) : trial[DEN_BITS-1:0];
        n_div.quo = {i_div.quo[Q_BITS-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;

endmodule
